### design/eap_pkg.sv
// Types and constants shared by the 6502 effective address unit.
package eap_pkg;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_READ_DATA = 1'b1;

    localparam logic KIND_READ_REQ = 1'b0;
    localparam logic KIND_ADDR_DONE = 1'b1;

    localparam logic [3:0] MODE_IMPLIED = 4'd0;
    localparam logic [3:0] MODE_ACCUM = 4'd1;
    localparam logic [3:0] MODE_IMM = 4'd2;
    localparam logic [3:0] MODE_ZP = 4'd3;
    localparam logic [3:0] MODE_ZPX = 4'd4;
    localparam logic [3:0] MODE_ZPY = 4'd5;
    localparam logic [3:0] MODE_ABS = 4'd6;
    localparam logic [3:0] MODE_ABSX = 4'd7;
    localparam logic [3:0] MODE_ABSY = 4'd8;
    localparam logic [3:0] MODE_REL = 4'd9;
    localparam logic [3:0] MODE_IND = 4'd10;
    localparam logic [3:0] MODE_INDX = 4'd11;
    localparam logic [3:0] MODE_INDY = 4'd12;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT_LO = 2'd1;
    localparam logic [1:0] PH_WAIT_HI = 2'd2;

    localparam logic [1:0] PEND_IND = 2'd0;
    localparam logic [1:0] PEND_INDX = 2'd1;
    localparam logic [1:0] PEND_INDY = 2'd2;

    typedef struct packed {
        logic        command;
        logic [3:0]  mode;
        logic [15:0] prog_counter;
        logic [7:0]  operand_low;
        logic [7:0]  operand_high;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  read_data;
    } item_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [1:0]  pending_mode;
        logic [15:0] pointer;
        logic [7:0]  low_byte;
        logic [7:0]  saved_y;
    } state_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] address;
        logic        has_address;
        logic        page_cross;
    } result_t;

endpackage

### design/cpu6502_effective_address.sv
// Top level of the 6502 effective address unit.
// An accepted item is held in the input register and its result in the result register.
// Throughput: one item per cycle, set by the single-pass calc stage between
// the input register and the result register; the result register stalls only on m_axis_tready.
// Reset clears both valid flags and the pointer-read state (phase idle, all fields zero).
module cpu6502_effective_address
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode, prog_counter, operand_low, operand_high, index_x, index_y, read_data, pad
    input  logic [63:0] s_axis_tdata,
    // command
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // address, has_address, page_cross, pad
    output logic [23:0] m_axis_tdata,
    // result_kind
    output logic        m_axis_tuser
);

    logic             in_valid_reg;
    eap_pkg::item_t   in_item_reg;
    eap_pkg::item_t   in_item_next;
    eap_pkg::state_t  state_reg;
    eap_pkg::state_t  state_next;
    logic             out_valid_reg;
    eap_pkg::result_t out_res_reg;
    eap_pkg::result_t calc_res;
    logic             calc_emit;
    logic             out_free;
    logic             consume;
    logic             in_xfer;

    assign in_item_next.command = s_axis_tuser;
    assign in_item_next.mode = s_axis_tdata[3:0];
    assign in_item_next.prog_counter = s_axis_tdata[19:4];
    assign in_item_next.operand_low = s_axis_tdata[27:20];
    assign in_item_next.operand_high = s_axis_tdata[35:28];
    assign in_item_next.index_x = s_axis_tdata[43:36];
    assign in_item_next.index_y = s_axis_tdata[51:44];
    assign in_item_next.read_data = s_axis_tdata[59:52];

    eap_calc u_calc
    (
        .item       (in_item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (calc_res),
        .emit       (calc_emit)
    );

    assign out_free = !out_valid_reg || m_axis_tready;
    assign consume = in_valid_reg && (!calc_emit || out_free);
    assign s_axis_tready = !in_valid_reg || consume;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= '0;
        end
        else
        begin
            if (in_xfer)
                in_valid_reg <= 1'b1;
            else if (consume)
                in_valid_reg <= 1'b0;
            if (consume)
                state_reg <= state_next;
            if (consume && calc_emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            in_item_reg <= in_item_next;
        if (consume && calc_emit)
            out_res_reg <= calc_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser = out_res_reg.result_kind;
    assign m_axis_tdata = {6'd0, out_res_reg.page_cross, out_res_reg.has_address,
                           out_res_reg.address};

    a_indirect_start: assert property (@(posedge clk) disable iff (!rst_n)
        consume && (in_item_reg.command == eap_pkg::CMD_START)
        && ((in_item_reg.mode == eap_pkg::MODE_IND) || (in_item_reg.mode == eap_pkg::MODE_INDX)
        || (in_item_reg.mode == eap_pkg::MODE_INDY))
        |=> state_reg.phase == eap_pkg::PH_WAIT_LO)
        else $error("indirect start did not enter pointer wait");

    a_req_pending: assert property (@(posedge clk) disable iff (!rst_n)
        consume && calc_emit && (calc_res.result_kind == eap_pkg::KIND_READ_REQ)
        |=> (state_reg.phase == eap_pkg::PH_WAIT_LO) || (state_reg.phase == eap_pkg::PH_WAIT_HI))
        else $error("read request issued without a pending pointer read");

    a_cross_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[17] |-> m_axis_tuser == eap_pkg::KIND_ADDR_DONE)
        else $error("page crossing flagged on a read request");

    a_no_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'd0)
        else $error("nonzero address on a result without address");

endmodule

### design/eap_calc.sv
// Single-pass address calculation and pointer-read sequencing for one item.
module eap_calc
(
    input  eap_pkg::item_t   item,
    input  eap_pkg::state_t  state,
    output eap_pkg::state_t  state_next,
    output eap_pkg::result_t result,
    output logic             emit
);

    logic [15:0] word;
    logic [15:0] rel_off;
    logic [15:0] base;
    logic [15:0] indy_sum;

    assign word = {item.operand_high, item.operand_low};
    assign rel_off = {{8{item.operand_low[7]}}, item.operand_low};
    assign base = {item.read_data, state.low_byte};
    assign indy_sum = base + {8'd0, state.saved_y};

    always_comb
    begin
        state_next = state;
        result.result_kind = eap_pkg::KIND_ADDR_DONE;
        result.address = 16'd0;
        result.has_address = 1'b1;
        result.page_cross = 1'b0;
        emit = 1'b1;
        if (item.command == eap_pkg::CMD_READ_DATA)
        begin
            state_next.phase = eap_pkg::PH_IDLE;
            if (state.phase == eap_pkg::PH_WAIT_LO)
            begin
                state_next.low_byte = item.read_data;
                state_next.pointer = {state.pointer[15:8], state.pointer[7:0] + 8'd1};
                state_next.phase = eap_pkg::PH_WAIT_HI;
                result.result_kind = eap_pkg::KIND_READ_REQ;
                result.address = state_next.pointer;
            end
            else if (state.phase == eap_pkg::PH_WAIT_HI)
            begin
                if (state.pending_mode == eap_pkg::PEND_INDY)
                begin
                    result.address = indy_sum;
                    result.page_cross = (indy_sum[15:8] != base[15:8]);
                end
                else
                begin
                    result.address = base;
                end
            end
            else
            begin
                emit = 1'b0;
            end
        end
        else
        begin
            state_next.phase = eap_pkg::PH_IDLE;
            unique case (item.mode)
                eap_pkg::MODE_IMM:  result.address = item.prog_counter + 16'd1;
                eap_pkg::MODE_ZP:   result.address = {8'd0, item.operand_low};
                eap_pkg::MODE_ZPX:  result.address = {8'd0, item.operand_low + item.index_x};
                eap_pkg::MODE_ZPY:  result.address = {8'd0, item.operand_low + item.index_y};
                eap_pkg::MODE_ABS:  result.address = word;
                eap_pkg::MODE_ABSX: result.address = word + {8'd0, item.index_x};
                eap_pkg::MODE_ABSY: result.address = word + {8'd0, item.index_y};
                eap_pkg::MODE_REL:  result.address = item.prog_counter + rel_off;
                eap_pkg::MODE_IND, eap_pkg::MODE_INDX, eap_pkg::MODE_INDY:
                begin
                    state_next.phase = eap_pkg::PH_WAIT_LO;
                    state_next.saved_y = item.index_y;
                    if (item.mode == eap_pkg::MODE_IND)
                    begin
                        state_next.pending_mode = eap_pkg::PEND_IND;
                        state_next.pointer = word;
                    end
                    else if (item.mode == eap_pkg::MODE_INDX)
                    begin
                        state_next.pending_mode = eap_pkg::PEND_INDX;
                        state_next.pointer = {8'd0, item.operand_low + item.index_x};
                    end
                    else
                    begin
                        state_next.pending_mode = eap_pkg::PEND_INDY;
                        state_next.pointer = {8'd0, item.operand_low};
                    end
                    result.result_kind = eap_pkg::KIND_READ_REQ;
                    result.address = state_next.pointer;
                end
                default:
                begin
                    // implied, accumulator and unused codes
                    result.has_address = 1'b0;
                end
            endcase
        end
    end

endmodule
